@@ hw/rtl/spe_pkg.sv @@
package spe_pkg;

    localparam int unsigned DataW = 32;
    localparam int unsigned PctW  = 7;
    localparam int unsigned DrawW = 7;
    localparam int unsigned MoveW = 2;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned WideW = 36;

    localparam logic [PctW-1:0] PctReset = PctW'(50);
    localparam logic [DataW-1:0] StartReset = '0;
    localparam logic [DataW-1:0] StepReset = DataW'(1);
    localparam logic [PctW:0] DrawLimit = (PctW+1)'(99);

    localparam logic [CfgIdxW-1:0] CfgPct   = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] CfgStart = CfgIdxW'(1);

    localparam logic [MoveW-1:0] MoveNone = MoveW'(0);
    localparam logic [MoveW-1:0] MoveUp   = MoveW'(1);
    localparam logic [MoveW-1:0] MoveDown = MoveW'(2);

    localparam logic signed [WideW-1:0] WideMax = WideW'(32'sh7FFF_FFFF);
    localparam logic signed [WideW-1:0] WideMin = WideW'(32'sh8000_0000);
    localparam logic signed [WideW-1:0] WideOne = WideW'(32'sd1);

    typedef struct packed {
        logic [DataW-1:0] estimate;
        logic [DataW-1:0] step;
        logic             dir_up;
    } t_state;

    function automatic logic signed [WideW-1:0] sx(input logic [DataW-1:0] v);
        return WideW'($signed(v));
    endfunction

    function automatic logic signed [WideW-1:0] sat(input logic signed [WideW-1:0] v);
        logic signed [WideW-1:0] r;
        r = v;
        if (v > WideMax) begin
            r = WideMax;
        end else if (v < WideMin) begin
            r = WideMin;
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/spe_update.sv @@
module spe_update (
    input  spe_pkg::t_state                 i_state,
    input  logic [spe_pkg::DataW-1:0]       i_sample,
    input  logic [spe_pkg::DrawW-1:0]       i_draw,
    input  logic [spe_pkg::PctW-1:0]        i_pct,
    output spe_pkg::t_state                 o_state,
    output logic [spe_pkg::MoveW-1:0]       o_move
);

    logic signed [spe_pkg::WideW-1:0] cur_est;
    logic signed [spe_pkg::WideW-1:0] cur_step;
    logic signed [spe_pkg::WideW-1:0] smp;
    logic signed [spe_pkg::WideW-1:0] step1;
    logic signed [spe_pkg::WideW-1:0] eff;
    logic signed [spe_pkg::WideW-1:0] est2;
    logic signed [spe_pkg::WideW-1:0] over;
    logic signed [spe_pkg::WideW-1:0] step2;
    logic signed [spe_pkg::WideW-1:0] step3;
    logic signed [spe_pkg::WideW-1:0] est3;
    logic [spe_pkg::PctW:0] draw_sum;
    logic up;
    logic dn;
    logic same;
    logic pass;

    always_comb begin
        cur_est  = spe_pkg::sx(i_state.estimate);
        cur_step = spe_pkg::sx(i_state.step);
        smp      = spe_pkg::sx(i_sample);
        draw_sum = {1'b0, i_draw} + {1'b0, i_pct};
        up = (smp > cur_est) && (draw_sum > spe_pkg::DrawLimit);
        dn = !up && (smp < cur_est) && (i_draw > i_pct);
        same = up ? i_state.dir_up : !i_state.dir_up;
        step1 = spe_pkg::sat(same ? cur_step + spe_pkg::WideOne
                                  : cur_step - spe_pkg::WideOne);
        eff  = (step1 > 0) ? step1 : spe_pkg::WideOne;
        est2 = up ? cur_est + eff : cur_est - eff;
        pass = up ? (est2 > smp) : (est2 < smp);
        over = up ? est2 - smp : smp - est2;
        // clamp at the sample and give back the overshoot
        step2 = pass ? spe_pkg::sat(step1 - over) : step1;
        est3  = pass ? smp : est2;
        step3 = (!same && step2 > spe_pkg::WideOne) ? spe_pkg::WideOne : step2;

        o_state = i_state;
        o_move  = spe_pkg::MoveNone;
        if (up || dn) begin
            o_state.estimate = est3[spe_pkg::DataW-1:0];
            o_state.step     = step3[spe_pkg::DataW-1:0];
            o_state.dir_up   = up;
            o_move           = up ? spe_pkg::MoveUp : spe_pkg::MoveDown;
        end
    end

endmodule

@@ hw/rtl/streaming_percentile_estimator_unit.sv @@
// an accepted item passes through the input register, then the result register
// throughput: one item per cycle unless a stalled output holds a result; the
// estimate update is a single compare, add and clamp pass between them
// reset (synchronous, active low): percentile 50, start estimate 0, estimate 0,
// step 1, direction up, both pipeline registers empty
module streaming_percentile_estimator_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [spe_pkg::DataW-1:0]     i_sample_value,
    input  logic [spe_pkg::DrawW-1:0]     i_random_draw,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [spe_pkg::DataW-1:0]     o_estimate_now,
    output logic [spe_pkg::MoveW-1:0]     o_move_made,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [spe_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [spe_pkg::DataW-1:0]     i_cfg_data
);

    logic                         r_in_vld;
    logic [spe_pkg::DataW-1:0]    r_sample;
    logic [spe_pkg::DrawW-1:0]    r_draw;
    logic                         r_out_vld;
    logic [spe_pkg::DataW-1:0]    r_est_out;
    logic [spe_pkg::MoveW-1:0]    r_move_out;
    logic [spe_pkg::PctW-1:0]     r_pct;
    spe_pkg::t_state              r_state;
    spe_pkg::t_state              n_state;
    logic [spe_pkg::MoveW-1:0]    n_move;
    logic                         advance;
    logic                         cfg_wr;

    assign advance     = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall  = r_in_vld && !advance;
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    spe_update u_update (
        .i_state  (r_state),
        .i_sample (r_sample),
        .i_draw   (r_draw),
        .i_pct    (r_pct),
        .o_state  (n_state),
        .o_move   (n_move)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_pct     <= spe_pkg::PctReset;
            r_state   <= '{estimate: spe_pkg::StartReset, step: spe_pkg::StepReset,
                           dir_up: 1'b1};
        end else begin
            if (!o_in_stall) begin
                r_in_vld <= i_in_valid;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
                r_state   <= n_state;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (cfg_wr && i_cfg_index == spe_pkg::CfgPct) begin
                r_pct <= i_cfg_data[spe_pkg::PctW-1:0];
            end
            if (cfg_wr && i_cfg_index == spe_pkg::CfgStart) begin
                r_state <= '{estimate: i_cfg_data, step: spe_pkg::StepReset,
                             dir_up: 1'b1};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_sample <= i_sample_value;
            r_draw   <= i_random_draw;
        end
        if (advance) begin
            r_est_out  <= n_state.estimate;
            r_move_out <= n_move;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_estimate_now = r_est_out;
    assign o_move_made    = r_move_out;

    a_stall_only_backed_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_vld && i_out_stall))
        else $error("input stalled while result path is free");

    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_vld)
        else $error("advanced item did not reach the result register");

    a_up_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && n_move == spe_pkg::MoveUp)
            |-> ($signed(n_state.estimate) <= $signed(r_sample)))
        else $error("upward move passed the sample");

    a_down_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && n_move == spe_pkg::MoveDown)
            |-> ($signed(n_state.estimate) >= $signed(r_sample)))
        else $error("downward move passed the sample");

    a_no_move_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && n_move == spe_pkg::MoveNone) |-> (n_state == r_state))
        else $error("state changed without a move");

endmodule

@@ test/spe_checker.sv @@
module spe_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic [spe_pkg::DataW-1:0]   i_sample_value,
    input  logic [spe_pkg::DrawW-1:0]   i_random_draw,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic [spe_pkg::DataW-1:0]   i_estimate_now,
    input  logic [spe_pkg::MoveW-1:0]   i_move_made,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [spe_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [spe_pkg::DataW-1:0]   i_cfg_data,
    output int                          o_fail_count,
    output int                          o_pending
);
    import spe_pkg::*;

    localparam longint S32Max = 64'sd2147483647;
    localparam longint S32Min = -64'sd2147483648;

    typedef struct packed {
        logic [DataW-1:0] est;
        logic [MoveW-1:0] mv;
    } est_move_t;

    logic [PctW-1:0]          pct_q;
    logic signed [DataW-1:0]  est_q;
    logic signed [DataW-1:0]  step_q;
    logic                     up_q;
    est_move_t                predicted_moves[$];

    function automatic longint clamp_s32(input longint v);
        if (v > S32Max) begin
            return S32Max;
        end
        if (v < S32Min) begin
            return S32Min;
        end
        return v;
    endfunction

    function automatic est_move_t fold_sample(input logic [DataW-1:0] smp,
                                              input logic [DrawW-1:0] drw);
        longint    s;
        longint    e;
        longint    st;
        longint    p;
        longint    d;
        est_move_t r;
        s = longint'($signed(smp));
        e = longint'(est_q);
        st = longint'(step_q);
        p = longint'(pct_q);
        d = longint'(drw);
        r.mv = MoveNone;
        if (s > e && d > longint'(DrawLimit) - p) begin
            st = clamp_s32(st + (up_q ? 1 : -1));
            e = e + ((st > 0) ? st : 1);
            if (e > s) begin
                st = clamp_s32(st - (e - s));
                e = s;
            end
            if (!up_q && st > 1) begin
                st = 1;
            end
            up_q = 1'b1;
            r.mv = MoveUp;
        end else if (s < e && d > p) begin
            st = clamp_s32(st + (up_q ? -1 : 1));
            e = e - ((st > 0) ? st : 1);
            if (e < s) begin
                st = clamp_s32(st - (s - e));
                e = s;
            end
            if (up_q && st > 1) begin
                st = 1;
            end
            up_q = 1'b0;
            r.mv = MoveDown;
        end
        est_q = 32'(clamp_s32(e));
        step_q = 32'(clamp_s32(st));
        r.est = est_q;
        return r;
    endfunction

    always @(posedge i_clk) begin
        est_move_t want;
        if (!i_rst_n) begin
            pct_q = PctReset;
            est_q = StartReset;
            step_q = StepReset;
            up_q = 1'b1;
            predicted_moves.delete();
            o_fail_count = 0;
            o_pending = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (predicted_moves.size() == 0) begin
                    $display("%0t: unexpected item estimate_now %0d move_made %0d",
                             $time, $signed(i_estimate_now), i_move_made);
                    o_fail_count++;
                end else begin
                    want = predicted_moves.pop_front();
                    if (i_estimate_now !== want.est) begin
                        $display("%0t: estimate_now expected %0d got %0d",
                                 $time, $signed(want.est), $signed(i_estimate_now));
                        o_fail_count++;
                    end
                    if (i_move_made !== want.mv) begin
                        $display("%0t: move_made expected %0d got %0d",
                                 $time, want.mv, i_move_made);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CfgPct) begin
                    pct_q = i_cfg_data[PctW-1:0];
                end else if (i_cfg_index == CfgStart) begin
                    est_q = i_cfg_data;
                    step_q = StepReset;
                    up_q = 1'b1;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predicted_moves.push_back(fold_sample(i_sample_value, i_random_draw));
            end
            o_pending = predicted_moves.size();
        end
    end

endmodule

@@ test/tb.sv @@
module tb;
    import spe_pkg::*;

    localparam int ResetCycles  = 8;
    localparam int HoldCycles   = 400;
    localparam int IdleLimit    = 4000;
    localparam int SettleCycles = 6;
    localparam int PhaseItems   = 305;
    localparam int PhaseCount   = 6;

    localparam logic [CfgIdxW-1:0] CfgSpareA = CfgIdxW'(2);
    localparam logic [CfgIdxW-1:0] CfgSpareB = CfgIdxW'(3);
    localparam logic [DataW-1:0]   SampleMax = 32'h7FFF_FFFF;
    localparam logic [DataW-1:0]   SampleMin = 32'h8000_0000;

    typedef enum logic [2:0] {PhFree, PhSendIdle, PhRecvStall, PhBoth, PhHold} pace_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [DataW-1:0]   sample = '0;
    logic [DrawW-1:0]   draw = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [DataW-1:0]   estimate_now;
    logic [MoveW-1:0]   move_made;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CfgIdxW-1:0] cfg_index = '0;
    logic [DataW-1:0]   cfg_data = '0;
    int                 fail_count;
    int                 pending;
    pace_t              pace = PhFree;
    int                 hold_left = 0;
    bit                 hold_taken = 1'b0;
    int                 idle_cycles = 0;

    streaming_percentile_estimator_unit i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_sample_value (sample),
        .i_random_draw  (draw),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_estimate_now (estimate_now),
        .o_move_made    (move_made),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    spe_checker u_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_sample_value (sample),
        .i_random_draw  (draw),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_estimate_now (estimate_now),
        .i_move_made    (move_made),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always #1 clk = ~clk;

    function automatic bit sender_waits();
        case (pace)
            PhSendIdle: return $urandom_range(0, 99) < 58;
            PhBoth:     return $urandom_range(0, 99) < 7;
            default:    return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (pace)
            PhRecvStall: return $urandom_range(0, 99) < 58;
            PhBoth:      return $urandom_range(0, 99) < 7;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic logic [DataW-1:0] pick_sample(input logic [DataW-1:0] center);
        case ($urandom_range(0, 9))
            0, 1:    return $urandom;
            2:       return ($urandom_range(0, 1) != 0) ? SampleMax : SampleMin;
            default: return center + DataW'($urandom_range(0, 128)) - DataW'(64);
        endcase
    endfunction

    function automatic logic [DrawW-1:0] pick_draw();
        if ($urandom_range(0, 99) < 85) begin
            return DrawW'($urandom_range(0, 99));
        end
        return DrawW'($urandom_range(0, 127));
    endfunction

    // receiver side, with one long hold-off to back the block up
    always @(negedge clk) begin
        if (hold_left != 0) begin
            out_stall = 1'b1;
            hold_left--;
        end else if (pace == PhHold && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = HoldCycles - 1;
            out_stall = 1'b1;
        end else begin
            out_stall = receiver_stalls();
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IdleLimit) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic push_sample(input logic [DataW-1:0] smp, input logic [DrawW-1:0] drw);
        @(negedge clk);
        while (sender_waits()) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        sample = smp;
        draw = drw;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        cfg_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SettleCycles) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic load_setting(input logic [PctW-1:0] pct, input logic [DataW-1:0] start);
        logic [DataW-1:0] noisy;
        noisy = $urandom;
        noisy[PctW-1:0] = pct;
        settle();
        write_reg(CfgPct, noisy);
        write_reg(CfgStart, start);
        write_reg(($urandom_range(0, 1) != 0) ? CfgSpareA : CfgSpareB, $urandom);
        settle();
    endtask

    initial begin
        logic [PctW-1:0]  pct;
        logic [DataW-1:0] start;
        repeat (ResetCycles) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset setting: percentile 50, estimate 0
        push_sample(32'd0, 7'd99);
        push_sample(32'd100, 7'd49);
        push_sample(32'd100, 7'd50);
        push_sample(32'd100, 7'd99);
        push_sample(32'd6, 7'd127);
        push_sample(-32'sd5, 7'd50);
        push_sample(-32'sd5, 7'd51);
        push_sample(SampleMin, 7'd0);
        push_sample(SampleMax, 7'd127);
        push_sample(SampleMin, 7'd127);

        load_setting(7'd0, SampleMax);
        push_sample(SampleMax, 7'd127);
        push_sample(SampleMin, 7'd0);
        push_sample(SampleMin, 7'd1);
        push_sample(SampleMax, 7'd99);
        push_sample(SampleMax, 7'd100);

        load_setting(7'd100, SampleMin);
        push_sample(SampleMax, 7'd0);
        push_sample(SampleMin, 7'd100);
        push_sample(SampleMin, 7'd101);

        load_setting(7'd127, 32'd0);
        push_sample(32'd5, 7'd0);
        push_sample(-32'sd5, 7'd127);

        for (int ph = 0; ph < PhaseCount; ph++) begin
            case (ph)
                0: begin
                    pct = 7'd0;
                    start = SampleMax;
                end
                1: begin
                    pct = 7'd100;
                    start = SampleMin;
                end
                2: begin
                    pct = 7'd127;
                    start = $urandom;
                end
                3: begin
                    pct = PctW'($urandom_range(1, 99));
                    start = DataW'($urandom_range(0, 200)) - DataW'(100);
                end
                4: begin
                    pct = 7'd90;
                    start = $urandom;
                end
                default: begin
                    pct = PctW'($urandom_range(0, 127));
                    start = '0;
                end
            endcase
            load_setting(pct, start);
            case (ph)
                1:       pace = PhSendIdle;
                2:       pace = PhRecvStall;
                3:       pace = PhBoth;
                4:       pace = PhHold;
                default: pace = PhFree;
            endcase
            repeat (PhaseItems) push_sample(pick_sample(start), pick_draw());
        end

        settle();
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/spe_pkg.sv
hw/rtl/spe_update.sv
hw/rtl/streaming_percentile_estimator_unit.sv
test/spe_checker.sv
test/tb.sv
